/* hdl/taps_pkg.sv */
package taps_pkg;

  localparam int unsigned DIST_BITS_DEF = 16;
  localparam int unsigned TOL_W  = 8;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned X_W    = 32;
  localparam int unsigned Y_W    = 20;
  localparam int unsigned HELD_W = 16;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd30;
  localparam logic [Y_W-1:0]   Y_MAX     = '1;
  localparam logic [X_W-1:0]   X_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [X_W-1:0]   X_NEG_LIM = 32'h8000_0000;

  // Width of the rounded-quotient numerator, which is also the divider's step count.
  function automatic int unsigned num_width(int unsigned dist_bits);
    return 2 * dist_bits + 5;
  endfunction

  // Width of the square root of (10*bp)^2, which is also the root's step count.
  function automatic int unsigned root_width(int unsigned dist_bits);
    return dist_bits + 4;
  endfunction

  typedef enum logic [1:0] {
    FAIL_NONE,
    FAIL_STARBOARD,
    FAIL_PORT,
    FAIL_TRIANGLE
  } failure_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_BP,
    MUL_PS,
    MUL_BS,
    MUL_R,
    MUL_Q
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ABS
  } acc_op_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CHK,
    OP_MAG5,
    OP_NUM,
    OP_DIV,
    OP_CLAMP,
    OP_X2,
    OP_RAD,
    OP_SQRT,
    OP_STORE,
    OP_FAIL,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_DIV,
    CNT_SQRT
  } cnt_op_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_BAD,
    JMP_LOOP,
    JMP_ALWAYS,
    JMP_END
  } jmp_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_CHK    = 4'd0;
  localparam pc_t PC_SQ_PS  = 4'd1;
  localparam pc_t PC_SQ_BS  = 4'd2;
  localparam pc_t PC_SUB    = 4'd3;
  localparam pc_t PC_ABS    = 4'd4;
  localparam pc_t PC_MAG5   = 4'd5;
  localparam pc_t PC_NUM    = 4'd6;
  localparam pc_t PC_DIV    = 4'd7;
  localparam pc_t PC_CLAMP  = 4'd8;
  localparam pc_t PC_SQ_Q   = 4'd9;
  localparam pc_t PC_SQ_R   = 4'd10;
  localparam pc_t PC_RAD    = 4'd11;
  localparam pc_t PC_SQRT   = 4'd12;
  localparam pc_t PC_STORE  = 4'd13;
  localparam pc_t PC_EMIT   = 4'd14;
  localparam pc_t PC_FAIL   = 4'd15;

  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    dp_op_e   op;
    cnt_op_e  cnt;
    jmp_e     jmp;
    pc_t      target;
  } ucode_t;

  typedef struct packed {
    logic round_bad;
  } stat_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              fresh;
    logic              have;
    logic              stale;
    failure_e          code;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [HELD_W-1:0] held_port;
    logic [HELD_W-1:0] held_starboard;
  } res_t;

  localparam ucode_t UC_IDLE = '{
    mul_sel: MUL_NONE, acc_op: ACC_HOLD, op: OP_NONE,
    cnt: CNT_NONE, jmp: JMP_NEXT, target: PC_CHK
  };

  // The solver program. Each square is registered in the product register and used by the next step.
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    w = UC_IDLE;
    unique case (pc)
      PC_CHK:   begin
        w.mul_sel = MUL_BP;
        w.op      = OP_CHK;
        w.jmp     = JMP_BAD;
        w.target  = PC_FAIL;
      end
      PC_SQ_PS: begin
        w.mul_sel = MUL_PS;
        w.acc_op  = ACC_LOAD;
      end
      PC_SQ_BS: begin
        w.mul_sel = MUL_BS;
        w.acc_op  = ACC_ADD;
      end
      PC_SUB:   w.acc_op = ACC_SUB;
      PC_ABS:   w.acc_op = ACC_ABS;
      PC_MAG5:  w.op = OP_MAG5;
      PC_NUM:   begin
        w.op  = OP_NUM;
        w.cnt = CNT_DIV;
      end
      PC_DIV:   begin
        w.op     = OP_DIV;
        w.jmp    = JMP_LOOP;
        w.target = PC_DIV;
      end
      PC_CLAMP: w.op = OP_CLAMP;
      PC_SQ_Q:  w.mul_sel = MUL_Q;
      PC_SQ_R:  begin
        w.mul_sel = MUL_R;
        w.op      = OP_X2;
      end
      PC_RAD:   begin
        w.op  = OP_RAD;
        w.cnt = CNT_SQRT;
      end
      PC_SQRT:  begin
        w.op     = OP_SQRT;
        w.jmp    = JMP_LOOP;
        w.target = PC_SQRT;
      end
      PC_STORE: w.op = OP_STORE;
      PC_EMIT:  begin
        w.op  = OP_EMIT;
        w.jmp = JMP_END;
      end
      PC_FAIL:  begin
        w.op     = OP_FAIL;
        w.jmp    = JMP_ALWAYS;
        w.target = PC_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/two_anchor_position_solver_core.sv */
// Two-anchor position solver.
// Input channel (in_valid_i/in_ready_o) carries one ranging round per transaction:
// success flags, the port and starboard ranges, the baseline and a sequence number.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per round:
// the echoed sequence number, status flags, failure code and the held position.
// The tolerance register is to be written with cfg_we_i only while the block is idle;
// the block itself does not enforce this. Rounds are solved one at a time by a small
// microcoded sequencer. A good round runs the bit-serial divider (2*DIST_BITS+5 steps)
// and then the bit-serial square root (DIST_BITS+4 steps); a failed round skips both.
// The next round is accepted the cycle after a result is loaded into the output
// register, even if that result has not yet been taken. If the receiver stalls, a
// finished result waits in the output register and the following round's solve halts
// on its last step until it is taken.
// Reset clears the held position and flags and sets the tolerance to 30 cm.
module two_anchor_position_solver_core #(
  parameter int unsigned DIST_BITS = taps_pkg::DIST_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [taps_pkg::TOL_W-1:0]    triangle_tolerance_cm_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          starboard_ok_i,
  input  logic                          port_ok_i,
  input  logic [DIST_BITS-1:0]          dist_starboard_cm_i,
  input  logic [DIST_BITS-1:0]          dist_port_cm_i,
  input  logic [DIST_BITS-1:0]          baseline_cm_i,
  input  logic [taps_pkg::SEQ_W-1:0]    round_seq_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [taps_pkg::SEQ_W-1:0]    seq_echo_o,
  output logic                          fresh_o,
  output logic                          have_position_o,
  output logic                          is_stale_o,
  output logic [1:0]                    failure_code_o,
  output logic signed [taps_pkg::X_W-1:0] pos_x_mm_o,
  output logic [taps_pkg::Y_W-1:0]      pos_y_mm_o,
  output logic [taps_pkg::HELD_W-1:0]   held_port_cm_o,
  output logic [taps_pkg::HELD_W-1:0]   held_starboard_cm_o
);
  import taps_pkg::*;

  ucode_t ctrl;
  stat_t  stat;
  res_t   res;
  res_t   res_q;
  logic   busy;
  logic   in_fire;
  logic   out_free;
  logic   emit;
  logic   out_valid_q;

  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && !busy;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = (ctrl.op == OP_EMIT) && out_free;

  taps_seq #(
    .DIST_BITS (DIST_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  taps_datapath #(
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_tol_i           (triangle_tolerance_cm_i),
    .in_fire_i           (in_fire),
    .starboard_ok_i      (starboard_ok_i),
    .port_ok_i           (port_ok_i),
    .dist_starboard_cm_i (dist_starboard_cm_i),
    .dist_port_cm_i      (dist_port_cm_i),
    .baseline_cm_i       (baseline_cm_i),
    .round_seq_i         (round_seq_i),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .res_o               (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign seq_echo_o          = res_q.seq;
  assign fresh_o             = res_q.fresh;
  assign have_position_o     = res_q.have;
  assign is_stale_o          = res_q.stale;
  assign failure_code_o      = res_q.code;
  assign pos_x_mm_o          = res_q.x;
  assign pos_y_mm_o          = res_q.y;
  assign held_port_cm_o      = res_q.held_port;
  assign held_starboard_cm_o = res_q.held_starboard;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("a new round was accepted while the previous one was being solved");

  a_fresh_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fresh_o == (failure_code_o == FAIL_NONE)))
    else $error("fresh flag disagrees with the failure code");

  a_stale_needs_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_stale_o) |-> (have_position_o && !fresh_o))
    else $error("stale flag reported without a held position or on a fresh round");

endmodule

/* hdl/taps_datapath.sv */
module taps_datapath #(
  parameter int unsigned DIST_BITS = taps_pkg::DIST_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [taps_pkg::TOL_W-1:0]   cfg_tol_i,
  input  logic                         in_fire_i,
  input  logic                         starboard_ok_i,
  input  logic                         port_ok_i,
  input  logic [DIST_BITS-1:0]         dist_starboard_cm_i,
  input  logic [DIST_BITS-1:0]         dist_port_cm_i,
  input  logic [DIST_BITS-1:0]         baseline_cm_i,
  input  logic [taps_pkg::SEQ_W-1:0]   round_seq_i,
  input  taps_pkg::ucode_t             ctrl_i,
  output taps_pkg::stat_t              stat_o,
  output taps_pkg::res_t               res_o
);
  import taps_pkg::*;

  localparam int unsigned SQ_W   = 2 * DIST_BITS;
  localparam int unsigned ACC_W  = 2 * DIST_BITS + 2;
  localparam int unsigned MAG_W  = 2 * DIST_BITS + 1;
  localparam int unsigned MAG5_W = 2 * DIST_BITS + 4;
  localparam int unsigned NUM_W  = num_width(DIST_BITS);
  localparam int unsigned DEN_W  = DIST_BITS + 1;
  localparam int unsigned R_W    = DIST_BITS + 4;
  localparam int unsigned R2_W   = 2 * R_W;
  localparam int unsigned ROOT_W = root_width(DIST_BITS);
  localparam int unsigned SR_W   = DIST_BITS + 8;
  localparam int unsigned T_W    = DIST_BITS + 2;
  localparam int unsigned QE_W   = (NUM_W > X_W) ? NUM_W : X_W;
  localparam int unsigned YE_W   = (ROOT_W > Y_W) ? ROOT_W : Y_W;

  // Captured round
  logic                 sok_q, pok_q;
  logic [DIST_BITS-1:0] bs_q, bp_q, ps_q;
  logic [SEQ_W-1:0]     seq_q;

  // Working registers
  failure_e             code_q;
  logic [R_W-1:0]       r_q;
  logic [PROD_W-1:0]    prod_q;
  logic [ACC_W-1:0]     acc_q;
  logic                 neg_q;
  logic [MAG5_W-1:0]    mag5_q;
  logic [NUM_W-1:0]     numq_q;
  logic [DEN_W-1:0]     rem_q;
  logic [X_W-1:0]       qx_q;
  logic [PROD_W-1:0]    x2_q;
  logic [R2_W-1:0]      rad_q;
  logic [ROOT_W-1:0]    root_q;
  logic [SR_W-1:0]      srem_q;

  // Architectural state
  logic [TOL_W-1:0]     tol_q;
  logic                 valid_q, stale_q;
  logic [X_W-1:0]       sx_q;
  logic [Y_W-1:0]       sy_q;
  logic [HELD_W-1:0]    shp_q, shs_q;

  logic                 tri_ok;
  failure_e             code_c;
  logic [MUL_W-1:0]     mop;
  logic [PROD_W-1:0]    sq_c;
  logic [SQ_W-1:0]      sq_lo;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       div_sh;
  logic                 div_bit;
  logic [QE_W-1:0]      q_ext;
  logic [X_W-1:0]       lim;
  logic [X_W-1:0]       qx_c;
  logic [SR_W-1:0]      sr_sh;
  logic [SR_W-1:0]      sr_trial;
  logic                 sr_bit;
  logic [YE_W-1:0]      root_ext;
  logic [Y_W-1:0]       y_c;

  always_comb begin
    tri_ok = (T_W'(bp_q) + T_W'(bs_q) + T_W'(tol_q) >= T_W'(ps_q))
          && (T_W'(bp_q) + T_W'(ps_q) + T_W'(tol_q) >= T_W'(bs_q))
          && (T_W'(bs_q) + T_W'(ps_q) + T_W'(tol_q) >= T_W'(bp_q));
    if (!sok_q) begin
      code_c = FAIL_STARBOARD;
    end else if (!pok_q) begin
      code_c = FAIL_PORT;
    end else if ((ps_q == '0) || !tri_ok) begin
      code_c = FAIL_TRIANGLE;
    end else begin
      code_c = FAIL_NONE;
    end
  end

  assign stat_o.round_bad = (code_c != FAIL_NONE);

  // Shared squarer: every product in the solve is a square.
  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_BP:  mop = MUL_W'(bp_q);
      MUL_PS:  mop = MUL_W'(ps_q);
      MUL_BS:  mop = MUL_W'(bs_q);
      MUL_R:   mop = MUL_W'(r_q);
      MUL_Q:   mop = qx_q;
      default: mop = '0;
    endcase
  end

  assign sq_c  = PROD_W'(mop) * PROD_W'(mop);
  assign sq_lo = prod_q[SQ_W-1:0];

  // Restoring divider by 2*baseline, one quotient bit per step.
  assign den     = {ps_q, 1'b0};
  assign div_sh  = {rem_q, numq_q[NUM_W-1]};
  assign div_bit = (div_sh >= (DEN_W + 1)'(den));

  always_comb begin
    lim   = neg_q ? X_NEG_LIM : X_POS_LIM;
    q_ext = QE_W'(numq_q);
    qx_c  = (q_ext > QE_W'(lim)) ? lim : q_ext[X_W-1:0];
  end

  // Digit-by-digit root, two radicand bits per step.
  assign sr_sh    = {srem_q[SR_W-3:0], rad_q[R2_W-1 -: 2]};
  assign sr_trial = SR_W'({root_q, 2'b01});
  assign sr_bit   = (sr_sh >= sr_trial);

  assign root_ext = YE_W'(root_q);
  assign y_c      = (root_ext > YE_W'(Y_MAX)) ? Y_MAX : root_ext[Y_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      sok_q <= starboard_ok_i;
      pok_q <= port_ok_i;
      bs_q  <= dist_starboard_cm_i;
      bp_q  <= dist_port_cm_i;
      ps_q  <= baseline_cm_i;
      seq_q <= round_seq_i;
    end

    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= sq_c;
    end

    case (ctrl_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(sq_lo);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(sq_lo);
      ACC_SUB:  acc_q <= acc_q - ACC_W'(sq_lo);
      ACC_ABS:  begin
        neg_q <= acc_q[ACC_W-1];
        acc_q <= acc_q[ACC_W-1] ? ACC_W'(0) - acc_q : acc_q;
      end
      default: ;
    endcase

    case (ctrl_i.op)
      OP_CHK: begin
        code_q <= code_c;
        r_q    <= R_W'({bp_q, 3'b000}) + R_W'({bp_q, 1'b0});
      end
      OP_MAG5: mag5_q <= MAG5_W'({acc_q[MAG_W-1:0], 2'b00}) + MAG5_W'(acc_q[MAG_W-1:0]);
      OP_NUM: begin
        numq_q <= NUM_W'({mag5_q, 1'b0}) + NUM_W'(ps_q);
        rem_q  <= '0;
      end
      OP_DIV: begin
        rem_q  <= div_bit ? DEN_W'(div_sh - (DEN_W + 1)'(den)) : div_sh[DEN_W-1:0];
        numq_q <= {numq_q[NUM_W-2:0], div_bit};
      end
      OP_CLAMP: qx_q <= qx_c;
      OP_X2:    x2_q <= prod_q;
      OP_RAD: begin
        rad_q  <= (prod_q > x2_q) ? R2_W'(prod_q - x2_q) : '0;
        root_q <= '0;
        srem_q <= '0;
      end
      OP_SQRT: begin
        srem_q <= sr_bit ? sr_sh - sr_trial : sr_sh;
        root_q <= {root_q[ROOT_W-2:0], sr_bit};
        rad_q  <= {rad_q[R2_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= TOL_RESET;
      valid_q <= 1'b0;
      stale_q <= 1'b0;
      sx_q    <= '0;
      sy_q    <= '0;
      shp_q   <= '0;
      shs_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_tol_i;
      end
      if (ctrl_i.op == OP_STORE) begin
        valid_q <= 1'b1;
        stale_q <= 1'b0;
        sx_q    <= neg_q ? X_W'(0) - qx_q : qx_q;
        sy_q    <= y_c;
        shp_q   <= HELD_W'(bp_q);
        shs_q   <= HELD_W'(bs_q);
      end else if (ctrl_i.op == OP_FAIL) begin
        stale_q <= valid_q;
      end
    end
  end

  always_comb begin
    res_o.seq            = seq_q;
    res_o.fresh          = (code_q == FAIL_NONE);
    res_o.have           = valid_q;
    res_o.stale          = stale_q;
    res_o.code           = code_q;
    res_o.x              = sx_q;
    res_o.y              = sy_q;
    res_o.held_port      = shp_q;
    res_o.held_starboard = shs_q;
  end

endmodule

/* hdl/taps_seq.sv */
module taps_seq #(
  parameter int unsigned DIST_BITS = taps_pkg::DIST_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             out_free_i,
  input  taps_pkg::stat_t  stat_i,
  output taps_pkg::ucode_t ctrl_o,
  output logic             busy_o
);
  import taps_pkg::*;

  localparam int unsigned DIV_ITERS  = num_width(DIST_BITS);
  localparam int unsigned SQRT_ITERS = root_width(DIST_BITS);
  localparam int unsigned CNT_W      = $clog2(DIV_ITERS + 1);

  seq_state_e       state_q, state_d;
  pc_t              pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  ucode_t           word;

  assign word = ucode_rom(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          pc_d    = PC_CHK;
        end
      end
      SEQ_RUN: begin
        case (word.cnt)
          CNT_DIV:  cnt_d = CNT_W'(DIV_ITERS);
          CNT_SQRT: cnt_d = CNT_W'(SQRT_ITERS);
          default:  if (word.jmp == JMP_LOOP) cnt_d = cnt_q - 1'b1;
        endcase
        case (word.jmp)
          JMP_BAD:    pc_d = stat_i.round_bad ? word.target : pc_q + 1'b1;
          JMP_LOOP:   pc_d = (cnt_q != CNT_W'(1)) ? word.target : pc_q + 1'b1;
          JMP_ALWAYS: pc_d = word.target;
          JMP_END: begin
            // Hold on the final step until the output register can take the result.
            if (out_free_i) begin
              state_d = SEQ_IDLE;
            end
          end
          default:    pc_d = pc_q + 1'b1;
        endcase
      end
    endcase
  end

  always_comb begin
    busy_o = (state_q == SEQ_RUN);
    ctrl_o = (state_q == SEQ_RUN) ? word : UC_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= PC_CHK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
    end
  end

  a_loop_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN && word.jmp == JMP_LOOP) |-> (cnt_q != '0))
    else $error("loop step entered with an exhausted iteration count");

endmodule

/* verif/two_anchor_position_solver_checker.sv */
module two_anchor_position_solver_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [taps_pkg::TOL_W-1:0]    tolerance_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          starboard_ok_i,
  input  logic                          port_ok_i,
  input  logic [15:0]                   dist_starboard_cm_i,
  input  logic [15:0]                   dist_port_cm_i,
  input  logic [15:0]                   baseline_cm_i,
  input  logic [taps_pkg::SEQ_W-1:0]    round_seq_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [taps_pkg::SEQ_W-1:0]    seq_echo_i,
  input  logic                          fresh_i,
  input  logic                          have_position_i,
  input  logic                          is_stale_i,
  input  logic [1:0]                    failure_code_i,
  input  logic [taps_pkg::X_W-1:0]      pos_x_mm_i,
  input  logic [taps_pkg::Y_W-1:0]      pos_y_mm_i,
  input  logic [taps_pkg::HELD_W-1:0]   held_port_cm_i,
  input  logic [taps_pkg::HELD_W-1:0]   held_starboard_cm_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import taps_pkg::*;

  logic [TOL_W-1:0]  tolerance_cm = TOL_RESET;
  logic              have_fix = 1'b0;
  logic              fix_stale = 1'b0;
  logic [X_W-1:0]    fix_x_mm = '0;
  logic [Y_W-1:0]    fix_y_mm = '0;
  logic [HELD_W-1:0] fix_port_cm = '0;
  logic [HELD_W-1:0] fix_starboard_cm = '0;

  res_t solved_rounds_q[$];
  res_t exp_r;
  int   mismatches = 0;
  int   outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = outstanding;

  // Floor square root, one result bit per pair of operand bits.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    root = 0;
    rem  = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Works out the result of one round and updates the held position.
  function automatic res_t solve_round(input logic s_ok, input logic p_ok,
                                       input logic [15:0] bs, input logic [15:0] bp,
                                       input logic [15:0] ps, input logic [SEQ_W-1:0] seq);
    res_t            r;
    failure_e        code;
    longint unsigned lbs;
    longint unsigned lbp;
    longint unsigned lps;
    longint unsigned lt;
    longint unsigned plus_term;
    longint unsigned minus_term;
    longint unsigned mag;
    longint unsigned quo;
    longint unsigned radius_sq;
    longint unsigned along_sq;
    longint unsigned off_line;
    logic            neg;
    logic            tri_ok;
    lbs = bs;
    lbp = bp;
    lps = ps;
    lt  = tolerance_cm;
    tri_ok = (lbp + lbs + lt >= lps) && (lbp + lps + lt >= lbs) && (lbs + lps + lt >= lbp);
    if (!s_ok) begin
      code = FAIL_STARBOARD;
    end else if (!p_ok) begin
      code = FAIL_PORT;
    end else if (ps == 0 || !tri_ok) begin
      code = FAIL_TRIANGLE;
    end else begin
      code = FAIL_NONE;
    end

    if (code == FAIL_NONE) begin
      plus_term  = 5 * (lbp * lbp + lps * lps);
      minus_term = 5 * (lbs * lbs);
      neg = minus_term > plus_term;
      mag = neg ? minus_term - plus_term : plus_term - minus_term;
      // Round to nearest with halves going away from zero.
      quo = (2 * mag + lps) / (2 * lps);
      if (neg && quo > 64'h8000_0000) begin
        quo = 64'h8000_0000;
      end else if (!neg && quo > 64'h7FFF_FFFF) begin
        quo = 64'h7FFF_FFFF;
      end
      fix_x_mm  = neg ? X_W'(-quo) : X_W'(quo);
      radius_sq = (10 * lbp) * (10 * lbp);
      along_sq  = quo * quo;
      off_line  = (radius_sq > along_sq) ? floor_sqrt(radius_sq - along_sq) : 64'd0;
      fix_y_mm  = (off_line > 64'(Y_MAX)) ? Y_MAX : Y_W'(off_line);
      fix_port_cm      = bp;
      fix_starboard_cm = bs;
      have_fix  = 1'b1;
      fix_stale = 1'b0;
    end else begin
      fix_stale = have_fix;
    end

    r.seq            = seq;
    r.fresh          = (code == FAIL_NONE);
    r.have           = have_fix;
    r.stale          = fix_stale;
    r.code           = code;
    r.x              = fix_x_mm;
    r.y              = fix_y_mm;
    r.held_port      = fix_port_cm;
    r.held_starboard = fix_starboard_cm;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_cm     = TOL_RESET;
      have_fix         = 1'b0;
      fix_stale        = 1'b0;
      fix_x_mm         = '0;
      fix_y_mm         = '0;
      fix_port_cm      = '0;
      fix_starboard_cm = '0;
      solved_rounds_q.delete();
      outstanding      = 0;
    end else begin
      if (cfg_we_i) begin
        tolerance_cm = tolerance_i;
      end

      if (out_valid_i && out_ready_i) begin
        if (solved_rounds_q.size() == 0) begin
          $error("result transaction with seq_echo %0d but no round outstanding", seq_echo_i);
          mismatches++;
        end else begin
          exp_r = solved_rounds_q.pop_front();
          if (seq_echo_i != exp_r.seq) begin
            $error("seq_echo: expected %0d, actual %0d", exp_r.seq, seq_echo_i);
            mismatches++;
          end
          if (fresh_i != exp_r.fresh) begin
            $error("fresh: expected %0d, actual %0d", exp_r.fresh, fresh_i);
            mismatches++;
          end
          if (have_position_i != exp_r.have) begin
            $error("have_position: expected %0d, actual %0d", exp_r.have, have_position_i);
            mismatches++;
          end
          if (is_stale_i != exp_r.stale) begin
            $error("is_stale: expected %0d, actual %0d", exp_r.stale, is_stale_i);
            mismatches++;
          end
          if (failure_code_i != exp_r.code) begin
            $error("failure_code: expected %0d, actual %0d", exp_r.code, failure_code_i);
            mismatches++;
          end
          if (pos_x_mm_i != exp_r.x) begin
            $error("pos_x_mm: expected %0d, actual %0d", $signed(exp_r.x), $signed(pos_x_mm_i));
            mismatches++;
          end
          if (pos_y_mm_i != exp_r.y) begin
            $error("pos_y_mm: expected %0d, actual %0d", exp_r.y, pos_y_mm_i);
            mismatches++;
          end
          if (held_port_cm_i != exp_r.held_port) begin
            $error("held_port_cm: expected %0d, actual %0d", exp_r.held_port, held_port_cm_i);
            mismatches++;
          end
          if (held_starboard_cm_i != exp_r.held_starboard) begin
            $error("held_starboard_cm: expected %0d, actual %0d",
                   exp_r.held_starboard, held_starboard_cm_i);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        solved_rounds_q.push_back(solve_round(starboard_ok_i, port_ok_i, dist_starboard_cm_i,
                                              dist_port_cm_i, baseline_cm_i, round_seq_i));
      end
      outstanding = solved_rounds_q.size();
    end
  end

endmodule

/* verif/tb_two_anchor_position_solver_core.sv */
module tb_two_anchor_position_solver_core;
  timeunit 1ns;
  timeprecision 1ps;

  import taps_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int          ROUNDS_PER_PH = 256;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [TOL_W-1:0]    tol_value;
  logic                in_valid;
  logic                in_ready;
  logic                starboard_ok;
  logic                port_ok;
  logic [15:0]         dist_starboard;
  logic [15:0]         dist_port;
  logic [15:0]         baseline;
  logic [SEQ_W-1:0]    round_seq;
  logic                out_valid;
  logic                out_ready;
  logic [SEQ_W-1:0]    seq_echo;
  logic                fresh;
  logic                have_position;
  logic                is_stale;
  logic [1:0]          failure_code;
  logic signed [X_W-1:0] pos_x_mm;
  logic [Y_W-1:0]      pos_y_mm;
  logic [HELD_W-1:0]   held_port;
  logic [HELD_W-1:0]   held_starboard;

  int                  mismatches;
  int                  rounds_in_flight;
  int unsigned         cycle_count = 0;
  bit                  no_idle = 1'b0;
  logic [TOL_W-1:0]    cur_tol;

  two_anchor_position_solver_core i_dut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .cfg_we_i                (cfg_we),
    .triangle_tolerance_cm_i (tol_value),
    .in_valid_i              (in_valid),
    .in_ready_o              (in_ready),
    .starboard_ok_i          (starboard_ok),
    .port_ok_i               (port_ok),
    .dist_starboard_cm_i     (dist_starboard),
    .dist_port_cm_i          (dist_port),
    .baseline_cm_i           (baseline),
    .round_seq_i             (round_seq),
    .out_valid_o             (out_valid),
    .out_ready_i             (out_ready),
    .seq_echo_o              (seq_echo),
    .fresh_o                 (fresh),
    .have_position_o         (have_position),
    .is_stale_o              (is_stale),
    .failure_code_o          (failure_code),
    .pos_x_mm_o              (pos_x_mm),
    .pos_y_mm_o              (pos_y_mm),
    .held_port_cm_o          (held_port),
    .held_starboard_cm_o     (held_starboard)
  );

  two_anchor_position_solver_checker i_solver_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .tolerance_i         (tol_value),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .starboard_ok_i      (starboard_ok),
    .port_ok_i           (port_ok),
    .dist_starboard_cm_i (dist_starboard),
    .dist_port_cm_i      (dist_port),
    .baseline_cm_i       (baseline),
    .round_seq_i         (round_seq),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .seq_echo_i          (seq_echo),
    .fresh_i             (fresh),
    .have_position_i     (have_position),
    .is_stale_i          (is_stale),
    .failure_code_i      (failure_code),
    .pos_x_mm_i          (pos_x_mm),
    .pos_y_mm_i          (pos_y_mm),
    .held_port_cm_i      (held_port),
    .held_starboard_cm_i (held_starboard),
    .mismatch_count_o    (mismatches),
    .pending_o           (rounds_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure with the occasional long stall, always ready in the no_idle phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_ready = 1'b1;
      end else if ($urandom_range(199) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(100, 1)) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= 33);
      end
    end
  end

  // Presents one round and holds it until the transaction completes.
  task automatic send_round(input logic s_ok, input logic p_ok, input logic [15:0] bs,
                            input logic [15:0] bp, input logic [15:0] ps,
                            input logic [SEQ_W-1:0] seq);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    if (!no_idle && $urandom_range(24) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(80, 1)) @(negedge clk);
    end
    in_valid       = 1'b1;
    starboard_ok   = s_ok;
    port_ok        = p_ok;
    dist_starboard = bs;
    dist_port      = bp;
    baseline       = ps;
    round_seq      = seq;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_rounds();
    @(negedge clk);
    in_valid = 1'b0;
    while (rounds_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    drain_rounds();
    @(negedge clk);
    cfg_we    = 1'b1;
    tol_value = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_tol   = value;
  endtask

  initial begin : stimulus
    logic [TOL_W-1:0] tol_plan[5];
    logic             s_ok;
    logic             p_ok;
    logic [15:0]      bs;
    logic [15:0]      bp;
    logic [15:0]      ps;
    int               span;
    int               lo;
    int               hi;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    tol_value      = '0;
    in_valid       = 1'b0;
    starboard_ok   = 1'b0;
    port_ok        = 1'b0;
    dist_starboard = '0;
    dist_port      = '0;
    baseline       = '0;
    round_seq      = '0;
    cur_tol        = TOL_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Failures before any position exists (the port flag ignored on a starboard failure), then a first fix.
    send_round(1'b0, 1'b1, 16'd100, 16'd100, 16'd100, 16'd0);
    send_round(1'b0, 1'b0, 16'd100, 16'd100, 16'd100, 16'd1);
    send_round(1'b1, 1'b0, 16'd100, 16'd100, 16'd100, 16'd2);
    send_round(1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd3);
    send_round(1'b1, 1'b1, 16'd400, 16'd300, 16'd500, 16'd4);
    // The held position now goes stale.
    send_round(1'b0, 1'b1, 16'd400, 16'd300, 16'd500, 16'd5);
    send_round(1'b1, 1'b0, 16'd400, 16'd300, 16'd500, 16'd6);
    send_round(1'b1, 1'b1, 16'd100, 16'd100, 16'd1000, 16'd7);
    // Each triangle inequality exactly at the tolerance, then one centimetre past it.
    send_round(1'b1, 1'b1, 16'd100, 16'd100, 16'd230, 16'd8);
    send_round(1'b1, 1'b1, 16'd100, 16'd100, 16'd231, 16'd9);
    send_round(1'b1, 1'b1, 16'd230, 16'd100, 16'd100, 16'd10);
    send_round(1'b1, 1'b1, 16'd231, 16'd100, 16'd100, 16'd11);
    send_round(1'b1, 1'b1, 16'd100, 16'd230, 16'd100, 16'd12);
    send_round(1'b1, 1'b1, 16'd100, 16'd231, 16'd100, 16'd13);
    // Exact halves in x, rounded away from zero on both signs.
    send_round(1'b1, 1'b1, 16'd2, 16'd3, 16'd2, 16'd14);
    send_round(1'b1, 1'b1, 16'd3, 16'd2, 16'd2, 16'd15);
    send_round(1'b1, 1'b1, 16'd300, 16'd100, 16'd250, 16'd16);
    // x lies beyond the port range, so y is clipped to zero.
    send_round(1'b1, 1'b1, 16'd0, 16'd0, 16'd1, 16'd17);
    send_round(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_round(1'b1, 1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFE);
    send_round(1'b1, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_round(1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'h7FFF);

    tol_plan = '{8'd0, 8'd255, 8'd0, 8'd1, TOL_RESET};
    tol_plan[2] = TOL_W'($urandom_range(254, 2));

    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tol_plan[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < ROUNDS_PER_PH; n++) begin
        if ($urandom_range(9) < 8) begin
          // Mostly near-consistent geometry at a random scale, straddling the limits.
          span = (1 << $urandom_range(16, 1)) - 1;
          s_ok = 1'b1;
          p_ok = 1'b1;
          ps   = 16'($urandom_range(span, 1));
          bp   = 16'($urandom_range(span, 0));
          lo   = int'(bp) - int'(ps) - int'(cur_tol) - 4;
          hi   = int'(bp) + int'(ps) + int'(cur_tol) + 4;
          if (lo < 0) lo = 0;
          if (hi > 65535) hi = 65535;
          bs   = 16'($urandom_range(hi, lo));
        end else begin
          s_ok = 1'($urandom);
          p_ok = 1'($urandom);
          bs   = 16'($urandom);
          bp   = 16'($urandom);
          ps   = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        end
        send_round(s_ok, p_ok, bs, bp, ps, 16'($urandom));
        if ($urandom_range(149) == 0) begin
          drain_rounds();
        end
      end
    end

    drain_rounds();
    repeat (100) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
